// ----- rtl/rpd_pkg.sv -----
// Shared types and constants for the remote-console packet deframer.
// No dependencies; imported by rpd_parse and rcon_packet_deframer_top.
package rpd_pkg;

  localparam int CFG_W  = 13;
  localparam int TEXT_W = 12;

  localparam logic [CFG_W-1:0] MAX_PACKET_RESET = CFG_W'(1460);
  localparam logic [31:0]      MIN_LENGTH_WORD  = 32'd10;
  localparam int               LENGTH_BYTES     = 4;
  localparam int               HEADER_BYTES     = 12;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] STATUS_GOOD           = 2'd0;
  localparam logic [1:0] STATUS_BAD_LENGTH     = 2'd1;
  localparam logic [1:0] STATUS_NO_TERMINATOR  = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [7:0]        text_byte;
    logic [31:0]       request_id;
    logic [31:0]       packet_type;
    logic [TEXT_W-1:0] text_length;
    logic [1:0]        status;
  } rpd_result_t;

endpackage

// ----- rtl/rpd_parse.sv -----
// Per-byte packet parser: position counter, header words, body scan and close flag.
// Depends on rpd_pkg; produces at most one result per accepted byte, combinationally.
module rpd_parse
  import rpd_pkg::*;
#(
  parameter int PACKET_LIMIT_CEILING = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic [CFG_W-1:0]  max_packet_bytes,
  output logic              res_valid,
  output rpd_result_t       res
);

  localparam int POS_W = $clog2(PACKET_LIMIT_CEILING);
  localparam logic [32:0] CEILING = 33'(PACKET_LIMIT_CEILING);

  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [POS_W-1:0]  last_position, last_position_next;
  logic [31:0]       length_word, length_word_next;
  logic [31:0]       request_word, request_word_next;
  logic [31:0]       type_word, type_word_next;
  logic [TEXT_W-1:0] text_count, text_count_next;
  logic              terminator_seen, terminator_seen_next;
  logic              stream_closed, stream_closed_next;

  logic [31:0] full_length;
  logic [32:0] limit;
  logic [32:0] packet_size;
  logic        bad_length;
  logic [1:0]  lane;

  assign lane        = byte_position[1:0];
  assign full_length = {data_byte, length_word[23:0]};
  assign limit       = (33'(max_packet_bytes) > CEILING) ? CEILING : 33'(max_packet_bytes);
  assign packet_size = {1'b0, full_length} + 33'(LENGTH_BYTES);
  assign bad_length  = full_length[31] || (full_length < MIN_LENGTH_WORD) ||
                       (packet_size > limit);

  always_comb begin
    byte_position_next   = byte_position;
    last_position_next   = last_position;
    length_word_next     = length_word;
    request_word_next    = request_word;
    type_word_next       = type_word;
    text_count_next      = text_count;
    terminator_seen_next = terminator_seen;
    stream_closed_next   = stream_closed;
    res_valid            = 1'b0;
    res                  = '0;

    if (step && !stream_closed) begin
      if (byte_position < POS_W'(LENGTH_BYTES)) begin
        length_word_next[8*lane +: 8] = data_byte;
        byte_position_next            = byte_position + 1'b1;
        if (byte_position == POS_W'(LENGTH_BYTES - 1)) begin
          last_position_next = full_length[POS_W-1:0] + POS_W'(LENGTH_BYTES - 1);
          if (bad_length) begin
            res_valid            = 1'b1;
            res.kind             = KIND_REPORT;
            res.status           = STATUS_BAD_LENGTH;
            stream_closed_next   = 1'b1;
            byte_position_next   = '0;
            text_count_next      = '0;
            terminator_seen_next = 1'b0;
          end
        end
      end else if (byte_position < POS_W'(2 * LENGTH_BYTES)) begin
        request_word_next[8*lane +: 8] = data_byte;
        byte_position_next             = byte_position + 1'b1;
      end else if (byte_position < POS_W'(HEADER_BYTES)) begin
        type_word_next[8*lane +: 8] = data_byte;
        byte_position_next          = byte_position + 1'b1;
      end else if (byte_position == last_position) begin
        res_valid        = 1'b1;
        res.kind         = KIND_REPORT;
        res.request_id   = request_word;
        res.packet_type  = type_word;
        res.text_length  = text_count;
        if (!terminator_seen && data_byte != 8'd0) begin
          res.status         = STATUS_NO_TERMINATOR;
          stream_closed_next = 1'b1;
        end else begin
          res.status = STATUS_GOOD;
        end
        byte_position_next   = '0;
        text_count_next      = '0;
        terminator_seen_next = 1'b0;
      end else begin
        byte_position_next = byte_position + 1'b1;
        if (!terminator_seen) begin
          if (data_byte == 8'd0) begin
            terminator_seen_next = 1'b1;
          end else begin
            text_count_next = text_count + 1'b1;
            res_valid       = 1'b1;
            res.kind        = KIND_TEXT;
            res.text_byte   = data_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      last_position   <= '0;
      length_word     <= '0;
      request_word    <= '0;
      type_word       <= '0;
      text_count      <= '0;
      terminator_seen <= 1'b0;
      stream_closed   <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      last_position   <= last_position_next;
      length_word     <= length_word_next;
      request_word    <= request_word_next;
      type_word       <= type_word_next;
      text_count      <= text_count_next;
      terminator_seen <= terminator_seen_next;
      stream_closed   <= stream_closed_next;
    end
  end

  a_closed_sticks: assert property (@(posedge clk) disable iff (rst)
    stream_closed |=> stream_closed)
    else $error("closed stream reopened without reset");

  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    stream_closed |-> !res_valid)
    else $error("result produced on a closed stream");

  a_header_silent: assert property (@(posedge clk) disable iff (rst)
    (step && byte_position >= POS_W'(LENGTH_BYTES) && byte_position < POS_W'(HEADER_BYTES))
      |-> !res_valid)
    else $error("result produced during id or type bytes");

  a_text_counts: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_TEXT) |=> text_count == $past(text_count) + 1'b1)
    else $error("text byte emitted without counting");

endmodule

// ----- rtl/rcon_packet_deframer_top.sv -----
// Top level of the remote-console packet deframer: config register and output register.
// Depends on rpd_pkg and rpd_parse.
//
// One byte is accepted per clock whenever the output register is empty or being
// drained in the same cycle; its text byte or end-of-packet report, if any, appears
// in the output register in the cycle after the byte is accepted. Each byte takes one
// pass through the parser: a position counter and one compare against the packet's
// last position, plus a single length check on the fourth byte. A bad length or a
// missing NUL closes the stream, which then swallows all bytes until reset.
// max_packet_bytes is taken on the config channel in any cycle.
module rcon_packet_deframer_top
  import rpd_pkg::*;
#(
  parameter int PACKET_LIMIT_CEILING = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [7:0]        text_byte,
  output logic signed [31:0] request_id,
  output logic signed [31:0] packet_type,
  output logic [TEXT_W-1:0] text_length,
  output logic [1:0]        status
);

  logic [CFG_W-1:0] max_packet_bytes;
  logic             step;
  logic             res_valid;
  rpd_result_t      res;
  rpd_result_t      result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;

  rpd_parse #(
    .PACKET_LIMIT_CEILING(PACKET_LIMIT_CEILING)
  ) u_parse (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .data_byte        (data_byte),
    .max_packet_bytes (max_packet_bytes),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_bytes <= MAX_PACKET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_packet_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      result <= res;
    end
  end

  assign kind        = result.kind;
  assign text_byte   = result.text_byte;
  assign request_id  = result.request_id;
  assign packet_type = result.packet_type;
  assign text_length = result.text_length;
  assign status      = result.status;

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result)))
    else $error("stalled result changed or dropped");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !step)
    else $error("byte accepted while result stalled");

  a_text_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_TEXT) |-> (status == STATUS_GOOD && text_length == '0))
    else $error("text beat carries report fields");

endmodule
